// ===== src/warp_sync_barrier_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the warp sync barrier.
// They compile to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef WARP_SYNC_BARRIER_MACROS_SVH
`define WARP_SYNC_BARRIER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define WSB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("warp_sync_barrier: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("warp_sync_barrier: assertion failed");

`else

`define WSB_ASSERT_NOW(label, clk, rst, ante, cons)
`define WSB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/wsb_pkg.sv =====
// ---------------------------------------------------------------------------
// wsb_pkg
// Shared types, status codes and helpers of the warp sync barrier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsb_pkg;

   localparam int MAX_LANES = 32;
   localparam int LANES_W = 32;
   localparam int LANE_IDX_W = 5;
   localparam int COUNT_W = 6;
   localparam int STATUS_W = 3;

   localparam logic [COUNT_W-1:0] LANE_COUNT_RESET = 6'd32;

   localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID_MASK = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MASK_MISMATCH = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PENDING_MISMATCH = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd4;
   localparam logic [STATUS_W-1:0] ST_UNREADY = 3'd5;

   typedef struct packed {
      logic [LANES_W-1:0] member_mask;
      logic [LANES_W-1:0] issue_lanes;
      logic [LANES_W-1:0] mismatch_lanes;
      logic [31:0]        issue_pc;
      logic [31:0]        successor_pc;
      logic [LANES_W-1:0] valid_lanes;
      logic [LANES_W-1:0] ready_lanes;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [LANE_IDX_W-1:0] error_lane;
      logic [LANES_W-1:0]    wait_lanes;
      logic [LANES_W-1:0]    release_lanes;
      logic [31:0]           release_pc;
   } rsp_word_type;

   typedef struct packed {
      logic               active;
      logic [31:0]        pc;
      logic [LANES_W-1:0] members;
      logic [LANES_W-1:0] arrived;
   } barrier_state_type;

   // Priority encoder: index of the lowest set bit, zero when none is set.
   function automatic logic [LANE_IDX_W-1:0] lowest_lane(input logic [LANES_W-1:0] bits);
      logic [LANE_IDX_W-1:0] idx;
      idx = '0;
      for (int i = LANES_W - 1; i >= 0; i--) begin
         if (bits[i]) begin
            idx = LANE_IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== src/warp_sync_barrier.sv =====
// ---------------------------------------------------------------------------
// warp_sync_barrier
// Warp-level sync barrier for one warp. An accepted request word passes the
// input register, then the result register, on the way to its response word;
// one word per cycle is sustained while the output is not stalled, limited
// only by the read-modify-write of the barrier state. Synchronous reset empties
// both registers, clears the barrier state and sets lane_count to 32.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "warp_sync_barrier_macros.svh"

module warp_sync_barrier (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [wsb_pkg::COUNT_W-1:0]          csr_wr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [wsb_pkg::LANES_W-1:0]          req_member_mask,
   input  logic [wsb_pkg::LANES_W-1:0]          req_issue_lanes,
   input  logic [wsb_pkg::LANES_W-1:0]          req_mismatch_lanes,
   input  logic [31:0]                          req_issue_pc,
   input  logic [31:0]                          req_successor_pc,
   input  logic [wsb_pkg::LANES_W-1:0]          req_valid_lanes,
   input  logic [wsb_pkg::LANES_W-1:0]          req_ready_lanes,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [wsb_pkg::STATUS_W-1:0]         rsp_status,
   output logic [wsb_pkg::LANE_IDX_W-1:0]       rsp_error_lane,
   output logic [wsb_pkg::LANES_W-1:0]          rsp_wait_lanes,
   output logic [wsb_pkg::LANES_W-1:0]          rsp_release_lanes,
   output logic [31:0]                          rsp_release_pc
);

   logic                          s1_vld_ff, s1_vld_in;
   wsb_pkg::req_word_type         s1_word_ff, s1_word_in;
   logic                          rsp_vld_ff, rsp_vld_in;
   wsb_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;

   logic                          out_ready;
   logic                          s1_fire;
   logic                          req_fire;
   wsb_pkg::rsp_word_type         eval_rsp;
   logic                          eval_write;
   wsb_pkg::barrier_state_type    state_next;
   wsb_pkg::barrier_state_type    state;
   logic [wsb_pkg::COUNT_W-1:0]   lane_count;

   // The result register frees up when it is empty or being taken.
   assign out_ready = !rsp_vld_ff || !rsp_stall;
   assign s1_fire = s1_vld_ff && out_ready;
   assign req_stall = s1_vld_ff && !out_ready;
   assign req_fire = req_valid && !req_stall;

   always_comb begin
      s1_word_in = s1_word_ff;
      if (req_fire) begin
         s1_word_in.member_mask = req_member_mask;
         s1_word_in.issue_lanes = req_issue_lanes;
         s1_word_in.mismatch_lanes = req_mismatch_lanes;
         s1_word_in.issue_pc = req_issue_pc;
         s1_word_in.successor_pc = req_successor_pc;
         s1_word_in.valid_lanes = req_valid_lanes;
         s1_word_in.ready_lanes = req_ready_lanes;
      end
      s1_vld_in = req_fire || (s1_vld_ff && !s1_fire);
      rsp_word_in = s1_fire ? eval_rsp : rsp_word_ff;
      rsp_vld_in = s1_fire || (rsp_vld_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff <= s1_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   wsb_eval u_eval (
      .req         (s1_word_ff),
      .state       (state),
      .lane_count  (lane_count),
      .rsp         (eval_rsp),
      .state_write (eval_write),
      .state_next  (state_next)
   );

   wsb_state u_state (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .update      (s1_fire && eval_write),
      .state_next  (state_next),
      .state       (state),
      .lane_count  (lane_count)
   );

   assign rsp_valid = rsp_vld_ff;
   assign rsp_status = rsp_word_ff.status;
   assign rsp_error_lane = rsp_word_ff.error_lane;
   assign rsp_wait_lanes = rsp_word_ff.wait_lanes;
   assign rsp_release_lanes = rsp_word_ff.release_lanes;
   assign rsp_release_pc = rsp_word_ff.release_pc;

   // A failed check never asks lanes to wait or releases them.
   `WSB_ASSERT_NOW(a_fail_quiet, clock, reset,
      rsp_vld_ff && (rsp_word_ff.status != wsb_pkg::ST_OK),
      (rsp_word_ff.wait_lanes == '0) && (rsp_word_ff.release_lanes == '0)
         && (rsp_word_ff.release_pc == '0))

   // Waiting and release are exclusive within one word.
   `WSB_ASSERT_NOW(a_wait_or_release, clock, reset,
      rsp_vld_ff,
      (rsp_word_ff.wait_lanes == '0) || (rsp_word_ff.release_lanes == '0))

   // Arrivals are always a strict subset of the pending participants.
   `WSB_ASSERT_NOW(a_arrived_subset, clock, reset,
      state.active,
      ((state.arrived & ~state.members) == '0) && (state.arrived != state.members))

   // An idle barrier holds no leftover state.
   `WSB_ASSERT_NOW(a_idle_clean, clock, reset,
      !state.active,
      (state.members == '0) && (state.arrived == '0) && (state.pc == '0))

   // A release closes the barrier.
   `WSB_ASSERT_NEXT(a_release_closes, clock, reset,
      s1_fire && (eval_rsp.release_lanes != '0),
      !state.active)

endmodule

// ===== src/wsb_state.sv =====
// ---------------------------------------------------------------------------
// wsb_state
// Barrier state, updated when a word passes its checks, and lane count register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsb_state (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [wsb_pkg::COUNT_W-1:0]      csr_wr_data,
   input  logic                             update,
   input  wsb_pkg::barrier_state_type       state_next,
   output wsb_pkg::barrier_state_type       state,
   output logic [wsb_pkg::COUNT_W-1:0]      lane_count
);

   wsb_pkg::barrier_state_type state_ff, state_in;
   logic [wsb_pkg::COUNT_W-1:0] lane_count_ff, lane_count_in;

   always_comb begin
      state_in = update ? state_next : state_ff;
      lane_count_in = csr_wr_en ? csr_wr_data : lane_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         lane_count_ff <= wsb_pkg::LANE_COUNT_RESET;
      end else begin
         state_ff <= state_in;
         lane_count_ff <= lane_count_in;
      end
   end

   assign state = state_ff;
   assign lane_count = lane_count_ff;

endmodule

// ===== src/wsb_eval.sv =====
// ---------------------------------------------------------------------------
// wsb_eval
// Checks one sync word against the barrier state and forms the response
// and the next barrier state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsb_eval (
   input  wsb_pkg::req_word_type            req,
   input  wsb_pkg::barrier_state_type       state,
   input  logic [wsb_pkg::COUNT_W-1:0]      lane_count,
   output wsb_pkg::rsp_word_type            rsp,
   output logic                             state_write,
   output wsb_pkg::barrier_state_type       state_next
);

   logic [wsb_pkg::LANES_W:0]   lane_limit;
   logic                        bad_width;
   logic                        invalid;
   logic [wsb_pkg::LANES_W-1:0] mism;
   logic [wsb_pkg::LANES_W-1:0] unready;
   logic                        pend_bad;
   logic                        dup;
   logic                        unr;
   logic [wsb_pkg::LANES_W-1:0] base_members;
   logic [wsb_pkg::LANES_W-1:0] base_arrived;
   logic                        complete;

   always_comb begin
      // Mask of lanes below lane_count; only meaningful when the count is legal.
      lane_limit = ((wsb_pkg::LANES_W+1)'(1) << lane_count) - (wsb_pkg::LANES_W+1)'(1);
      bad_width = (lane_count == '0)
         || (lane_count > wsb_pkg::COUNT_W'(wsb_pkg::MAX_LANES));
      invalid = bad_width
         || ((req.member_mask & ~lane_limit[wsb_pkg::LANES_W-1:0]) != '0)
         || (req.member_mask == '0)
         || ((req.issue_lanes & ~req.member_mask) != '0)
         || ((req.member_mask & ~req.valid_lanes) != '0);
      mism = req.mismatch_lanes & req.issue_lanes;
      pend_bad = state.active
         && ((state.pc != req.issue_pc) || (state.members != req.member_mask));
      dup = state.active && ((state.arrived & req.issue_lanes) != '0);
      unready = req.member_mask & ~req.ready_lanes;
      unr = !state.active && (unready != '0);

      base_members = state.active ? state.members : req.member_mask;
      base_arrived = (state.active ? state.arrived : '0) | req.issue_lanes;
      complete = (base_arrived == base_members);

      rsp = '0;
      state_write = 1'b0;
      state_next = '0;
      if (invalid) begin
         rsp.status = wsb_pkg::ST_INVALID_MASK;
      end else if (mism != '0) begin
         rsp.status = wsb_pkg::ST_MASK_MISMATCH;
         rsp.error_lane = wsb_pkg::lowest_lane(mism);
      end else if (pend_bad) begin
         rsp.status = wsb_pkg::ST_PENDING_MISMATCH;
      end else if (dup) begin
         rsp.status = wsb_pkg::ST_DUPLICATE;
      end else if (unr) begin
         rsp.status = wsb_pkg::ST_UNREADY;
         rsp.error_lane = wsb_pkg::lowest_lane(unready);
      end else begin
         rsp.status = wsb_pkg::ST_OK;
         state_write = 1'b1;
         if (complete) begin
            // All participants are in: release them and close the barrier.
            rsp.release_lanes = base_members;
            rsp.release_pc = req.successor_pc;
         end else begin
            rsp.wait_lanes = req.issue_lanes;
            state_next.active = 1'b1;
            state_next.pc = req.issue_pc;
            state_next.members = base_members;
            state_next.arrived = base_arrived;
         end
      end
   end

endmodule

// ===== sim/warp_sync_barrier_checker.sv =====
// ---------------------------------------------------------------------------
// Warp sync barrier checker
// Watches the request and response channels of the barrier. For every
// accepted request word it works out the expected response from its own
// copy of the barrier state and the lane count. Each accepted response
// word is then compared field by field with the oldest expected one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module warp_sync_barrier_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [wsb_pkg::COUNT_W-1:0]          csr_wr_data,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  wsb_pkg::req_word_type                req_word,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  wsb_pkg::rsp_word_type                rsp_word,
   output int                                   fail_count,
   output int                                   pending_count,
   output int                                   release_count
);

   localparam int REPORT_LIMIT = 10;

   wsb_pkg::rsp_word_type       expected_words[$];
   wsb_pkg::barrier_state_type  barrier;
   logic [wsb_pkg::COUNT_W-1:0] lane_setting;
   int mismatches = 0;
   int releases = 0;

   assign fail_count = mismatches;
   assign release_count = releases;

   function automatic logic [wsb_pkg::LANE_IDX_W-1:0] first_lane(
      input logic [wsb_pkg::LANES_W-1:0] bits);
      for (int i = 0; i < wsb_pkg::LANES_W; i++) begin
         if (bits[i]) begin
            return wsb_pkg::LANE_IDX_W'(i);
         end
      end
      return '0;
   endfunction

   // Applies one sync issue to the tracked barrier and returns its response.
   // A failing issue leaves the barrier untouched.
   function automatic wsb_pkg::rsp_word_type resolve_sync(input wsb_pkg::req_word_type w);
      wsb_pkg::rsp_word_type       r;
      logic [wsb_pkg::LANES_W-1:0] above;
      logic [wsb_pkg::LANES_W-1:0] flagged;
      logic [wsb_pkg::LANES_W-1:0] unready;
      r = '0;
      // Lanes at or above the lane count; empty once the count reaches 32.
      above = {wsb_pkg::LANES_W{1'b1}} << lane_setting;
      if (lane_setting == '0 || lane_setting > wsb_pkg::MAX_LANES ||
          (w.member_mask & above) != '0 || w.member_mask == '0 ||
          (w.issue_lanes & ~w.member_mask) != '0 ||
          (w.member_mask & ~w.valid_lanes) != '0) begin
         r.status = wsb_pkg::ST_INVALID_MASK;
         return r;
      end
      flagged = w.mismatch_lanes & w.issue_lanes;
      if (flagged != '0) begin
         r.status = wsb_pkg::ST_MASK_MISMATCH;
         r.error_lane = first_lane(flagged);
         return r;
      end
      if (barrier.active) begin
         if (barrier.pc != w.issue_pc || barrier.members != w.member_mask) begin
            r.status = wsb_pkg::ST_PENDING_MISMATCH;
            return r;
         end
         if ((barrier.arrived & w.issue_lanes) != '0) begin
            r.status = wsb_pkg::ST_DUPLICATE;
            return r;
         end
      end else begin
         unready = w.member_mask & ~w.ready_lanes;
         if (unready != '0) begin
            r.status = wsb_pkg::ST_UNREADY;
            r.error_lane = first_lane(unready);
            return r;
         end
         barrier = '{active: 1'b1, pc: w.issue_pc, members: w.member_mask, arrived: '0};
      end
      barrier.arrived |= w.issue_lanes;
      r.status = wsb_pkg::ST_OK;
      if (barrier.arrived != barrier.members) begin
         r.wait_lanes = w.issue_lanes;
      end else begin
         r.release_lanes = barrier.members;
         r.release_pc = w.successor_pc;
         barrier = '0;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] seen);
      if (want !== seen) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      wsb_pkg::rsp_word_type want;
      if (reset) begin
         expected_words.delete();
         barrier = '0;
         lane_setting = wsb_pkg::LANE_COUNT_RESET;
         pending_count <= 0;
      end else begin
         // A response can never belong to a request accepted at the same edge,
         // so responses are matched before the new request word is predicted.
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: response word with nothing expected, status %0d",
                           $time, rsp_word.status);
               end
            end else begin
               want = expected_words.pop_front();
               check_field("status", want.status, rsp_word.status);
               check_field("error_lane", want.error_lane, rsp_word.error_lane);
               check_field("wait_lanes", want.wait_lanes, rsp_word.wait_lanes);
               check_field("release_lanes", want.release_lanes, rsp_word.release_lanes);
               check_field("release_pc", want.release_pc, rsp_word.release_pc);
               if (want.release_lanes != '0) begin
                  releases++;
               end
            end
         end
         if (csr_wr_en) begin
            lane_setting = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            expected_words = {expected_words, resolve_sync(req_word)};
         end
         pending_count <= expected_words.size();
      end
   end

endmodule

// ===== sim/warp_sync_barrier_tb.sv =====
// ---------------------------------------------------------------------------
// Warp sync barrier testbench
// Drives sync issue words into the barrier and random stalls on its output.
// A short directed sequence hits each error status and the empty issue case,
// then whole barrier episodes with random lane groups, mixed with spoiled
// words, run under a series of lane counts. The checker does the prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module warp_sync_barrier_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 200;
   localparam int PHASES = 10;
   localparam int PRESSURE_PHASE = 5;
   localparam int RANDOM_PHASE = 8;
   localparam logic [31:0] ALL_LANES = 32'hFFFF_FFFF;

   typedef enum int {
      SPOIL_RANDOM,
      SPOIL_PC,
      SPOIL_MEMBERS,
      SPOIL_REPEAT,
      SPOIL_DISAGREE,
      SPOIL_STRAY_ISSUE,
      SPOIL_INVALID_LANE,
      SPOIL_HIGH_LANE,
      SPOIL_UNREADY
   } spoil_kind_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_wr_en = 1'b0;
   logic [wsb_pkg::COUNT_W-1:0]         csr_wr_data = '0;
   logic                                req_valid = 1'b0;
   wsb_pkg::req_word_type               req_word = '0;
   logic                                rsp_stall = 1'b0;
   logic                                req_stall;
   logic                                rsp_valid;
   logic [wsb_pkg::STATUS_W-1:0]        rsp_status;
   logic [wsb_pkg::LANE_IDX_W-1:0]      rsp_error_lane;
   logic [wsb_pkg::LANES_W-1:0]         rsp_wait_lanes;
   logic [wsb_pkg::LANES_W-1:0]         rsp_release_lanes;
   logic [31:0]                         rsp_release_pc;
   wsb_pkg::rsp_word_type               rsp_seen;

   int fail_count;
   int pending_count;
   int release_count;
   int cycle_count = 0;
   int words_sent = 0;
   int rush_words = 0;
   bit sender_steady = 1'b0;
   bit rsp_steady = 1'b0;
   bit hold_rsp = 1'b0;
   int lane_plan[PHASES] = '{1, 2, 0, 63, 33, 17, 5, 31, 0, 32};

   assign rsp_seen = {rsp_status, rsp_error_lane, rsp_wait_lanes, rsp_release_lanes,
                      rsp_release_pc};

   warp_sync_barrier i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_member_mask    (req_word.member_mask),
      .req_issue_lanes    (req_word.issue_lanes),
      .req_mismatch_lanes (req_word.mismatch_lanes),
      .req_issue_pc       (req_word.issue_pc),
      .req_successor_pc   (req_word.successor_pc),
      .req_valid_lanes    (req_word.valid_lanes),
      .req_ready_lanes    (req_word.ready_lanes),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_error_lane     (rsp_error_lane),
      .rsp_wait_lanes     (rsp_wait_lanes),
      .rsp_release_lanes  (rsp_release_lanes),
      .rsp_release_pc     (rsp_release_pc)
   );

   warp_sync_barrier_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_seen),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .release_count (release_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Offers one word after a random gap and returns at the edge that takes it.
   task automatic send_word(input wsb_pkg::req_word_type w);
      int gap;
      if ($urandom_range(0, 39) == 0) begin
         sender_steady = !sender_steady;
      end
      gap = (sender_steady || rush_words > 0) ? 0 : $urandom_range(0, 14);
      if (rush_words > 0) begin
         rush_words--;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_lanes(input int lanes);
      csr_wr_en <= 1'b1;
      csr_wr_data <= wsb_pkg::COUNT_W'(lanes);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic direct(input logic [31:0] member, issue, mism, pc, succ, valid, ready);
      send_word('{member, issue, mism, pc, succ, valid, ready});
   endtask

   function automatic logic [31:0] pick_bit(input logic [31:0] mask);
      logic [31:0] b;
      if (mask == '0) begin
         return '0;
      end
      do b = 32'h1 << $urandom_range(0, 31); while ((b & mask) == '0);
      return b;
   endfunction

   function automatic wsb_pkg::req_word_type shape_word(input logic [31:0] member, issue,
                                                        pc, succ, input bit opening);
      wsb_pkg::req_word_type w;
      w.member_mask = member;
      w.issue_lanes = issue;
      w.mismatch_lanes = $urandom & ~issue;
      w.issue_pc = pc;
      w.successor_pc = succ;
      w.valid_lanes = member | $urandom;
      w.ready_lanes = opening ? (member | $urandom) : $urandom;
      return w;
   endfunction

   // Turns a well-formed word into one that must be refused, whatever state
   // the barrier is in, so the episode around it stays on track.
   function automatic wsb_pkg::req_word_type spoil_word(input wsb_pkg::req_word_type w,
                                                        input bit active,
                                                        input logic [31:0] arrived,
                                                        input int lanes);
      spoil_kind_type kind;
      logic [31:0]    bit_sel;
      kind = spoil_kind_type'($urandom_range(0, 8));
      if (active && kind == SPOIL_UNREADY) begin
         kind = SPOIL_PC;
      end
      if (!active && kind inside {SPOIL_PC, SPOIL_MEMBERS, SPOIL_REPEAT}) begin
         kind = SPOIL_UNREADY;
      end
      if (kind == SPOIL_REPEAT && arrived == '0) begin
         kind = SPOIL_PC;
      end
      if (kind == SPOIL_STRAY_ISSUE && &w.member_mask) begin
         kind = SPOIL_INVALID_LANE;
      end
      case (kind)
         SPOIL_RANDOM: begin
            w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            w.valid_lanes &= ~pick_bit(w.member_mask);
         end
         SPOIL_PC: w.issue_pc ^= $urandom | 32'h1;
         SPOIL_MEMBERS: w.member_mask ^= 32'h1 << $urandom_range(0, lanes - 1);
         SPOIL_REPEAT: begin
            w.issue_lanes |= pick_bit(arrived);
            w.mismatch_lanes &= ~w.issue_lanes;
         end
         SPOIL_DISAGREE: begin
            bit_sel = pick_bit(w.member_mask);
            w.issue_lanes |= bit_sel;
            w.mismatch_lanes |= bit_sel;
         end
         SPOIL_STRAY_ISSUE: w.issue_lanes |= pick_bit(~w.member_mask);
         SPOIL_INVALID_LANE: w.valid_lanes &= ~pick_bit(w.member_mask);
         SPOIL_HIGH_LANE: begin
            if (lanes < 32) begin
               w.member_mask |= pick_bit(ALL_LANES << lanes);
            end else begin
               w.member_mask = '0;
            end
         end
         SPOIL_UNREADY: w.ready_lanes &= ~pick_bit(w.member_mask);
         default: w.issue_pc = ~w.issue_pc;
      endcase
      return w;
   endfunction

   // One barrier from opening to release: the members arrive in random
   // groups, sometimes as an empty issue, with refused words in between.
   task automatic run_barrier(input int lanes);
      logic [31:0] lane_mask;
      logic [31:0] member;
      logic [31:0] remaining;
      logic [31:0] issue;
      logic [31:0] pc;
      logic [31:0] succ;
      int          groups;
      lane_mask = ALL_LANES >> (32 - lanes);
      case ($urandom_range(0, 3))
         0: member = lane_mask;
         1: member = 32'h1 << $urandom_range(0, lanes - 1);
         default: member = $urandom & lane_mask;
      endcase
      if (member == '0) begin
         member = lane_mask;
      end
      pc = $urandom;
      succ = $urandom;
      remaining = member;
      groups = 0;
      do begin
         if ($urandom_range(0, 5) == 0) begin
            send_word(spoil_word(shape_word(member, remaining & $urandom, pc, succ,
                                            groups == 0),
                                 groups != 0, member & ~remaining, lanes));
         end
         if (groups >= 3 || $urandom_range(0, 3) == 0) begin
            issue = remaining;
         end else if ($urandom_range(0, 9) == 0) begin
            issue = '0;
         end else begin
            issue = remaining & $urandom;
         end
         send_word(shape_word(member, issue, pc, succ, groups == 0));
         remaining &= ~issue;
         groups++;
      end while (remaining != '0);
   endtask

   initial begin : rsp_side
      int pause;
      wait (reset == 1'b0);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         if ($urandom_range(0, 39) == 0) begin
            rsp_steady = !rsp_steady;
         end
         pause = rsp_steady ? 0 : $urandom_range(0, 14);
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin : stimulus
      int lanes;
      int gen_lanes;
      int budget;
      int half;
      int target;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset lane count of 32.
      direct(ALL_LANES, ALL_LANES, '0, 32'h0, ALL_LANES, ALL_LANES, ALL_LANES);
      direct('0, '0, '0, 32'h10, 32'h20, ALL_LANES, ALL_LANES);
      direct(32'hF0, 32'h100, '0, 32'h10, 32'h20, ALL_LANES, ALL_LANES);
      direct(32'hF0, 32'h10, '0, 32'h10, 32'h20, 32'h70, ALL_LANES);
      direct(32'h8000_0000, 32'h8000_0000, ALL_LANES, 32'h10, 32'h20, ALL_LANES, ALL_LANES);
      direct(32'h3, 32'h1, 32'h3, 32'h10, 32'h20, ALL_LANES, ALL_LANES);
      // Disagreeing lanes outside the issuers do not count.
      direct(32'h3, 32'h1, 32'hFFFF_FFFC, 32'h10, 32'h20, ALL_LANES, ALL_LANES);
      direct(32'h3, 32'h2, '0, 32'h10, 32'h20, ALL_LANES, ALL_LANES);
      direct(ALL_LANES, 32'h1, '0, 32'h100, 32'h200, ALL_LANES, 32'h7FFF_FFFF);
      direct(32'hF0, 32'h10, '0, 32'h100, 32'h200, ALL_LANES, 32'h0F);
      direct(32'h0F, 32'h1, '0, ALL_LANES, 32'h0, ALL_LANES, 32'h0F);
      direct(32'h0F, 32'h2, '0, 32'hFFFF_FFFE, 32'h0, ALL_LANES, 32'h0F);
      direct(32'h1F, 32'h2, '0, ALL_LANES, 32'h0, ALL_LANES, ALL_LANES);
      direct(32'h0F, 32'h3, '0, ALL_LANES, 32'h0, ALL_LANES, 32'h0F);
      direct(32'h0F, 32'h0, '0, ALL_LANES, 32'h0, ALL_LANES, 32'h0F);
      // Readiness only matters when a barrier opens.
      direct(32'h0F, 32'h6, '0, ALL_LANES, 32'h0, ALL_LANES, 32'h0);
      direct(32'h0F, 32'h8, '0, ALL_LANES, 32'h1234_5678, ALL_LANES, 32'h0);
      direct(32'h3, 32'h0, '0, 32'h40, 32'h80, ALL_LANES, ALL_LANES);
      direct(32'h3, 32'h3, '0, 32'h40, ALL_LANES, ALL_LANES, ALL_LANES);
      direct(32'h1_0000, 32'h1_0000, '0, 32'h8000_0000, 32'h4, 32'h1_0000, 32'h1_0000);

      for (int phase = 0; phase < PHASES; phase++) begin
         lanes = (phase == RANDOM_PHASE) ? $urandom_range(3, 30) : lane_plan[phase];
         settle();
         write_lanes(lanes);
         if (lanes >= 1 && lanes <= wsb_pkg::MAX_LANES) begin
            gen_lanes = lanes;
            budget = 250;
         end else begin
            gen_lanes = $urandom_range(1, wsb_pkg::MAX_LANES);
            budget = 20;
         end
         if (phase == PRESSURE_PHASE) begin
            // The output holds off while words keep coming, filling the block.
            hold_rsp = 1'b1;
            rush_words = 40;
         end
         half = words_sent + budget / 2;
         target = words_sent + budget;
         while (words_sent < half) run_barrier(gen_lanes);
         if (phase == PRESSURE_PHASE) begin
            settle();
         end
         while (words_sent < target) run_barrier(gen_lanes);
      end

      settle();
      repeat (8) @(posedge clock);
      $display("Sent %0d sync words under %0d lane count settings, %0d barriers released.",
               words_sent, PHASES + 1, release_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/wsb_pkg.sv
src/wsb_state.sv
src/wsb_eval.sv
src/warp_sync_barrier.sv
sim/warp_sync_barrier_checker.sv
sim/warp_sync_barrier_tb.sv
